// File: rtl/bcs_pkg.sv
// Package for the battery cell statistics block.
// Holds the fixed field widths, the stored record layouts and the divider
// request and response types. Depends on nothing.
package bcs_pkg;

   // Fixed widths of the stream fields and internal accumulators.
   localparam int VOLT_W    = 16;
   localparam int TEMP_W    = 16;
   localparam int VSUM_W    = 22;
   localparam int TSUM_W    = 22;
   localparam int GOOD_W    = 7;
   localparam int BAD_W     = 7;
   localparam int STAT_W    = 17;
   localparam int TOTAL_W   = 27;
   localparam int AVS_W     = 21;
   localparam int BT_SUM_W  = 48;
   localparam int BT_CNT_W  = 32;
   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_CNT_W = 6;

   // Saturation limits of the running sums and good counts.
   localparam logic [VSUM_W-1:0]        VSUM_MAX = '1;
   localparam logic signed [TSUM_W:0]   TSUM_MAX = 23'sh0F_FFFF << 1 | 23'sd1;
   localparam logic signed [TSUM_W:0]   TSUM_MIN = -23'sd2097152;
   localparam logic [GOOD_W-1:0]        GOOD_MAX = '1;

   // Stored board voltage record.
   typedef struct packed {
      logic [BAD_W-1:0]  bad;
      logic [VSUM_W-1:0] sum;
      logic [VOLT_W-1:0] avg;
      logic [VOLT_W-1:0] mn;
      logic [VOLT_W-1:0] mx;
   } vrec_type;

   // Stored board temperature record.
   typedef struct packed {
      logic [BAD_W-1:0]         bad;
      logic signed [TEMP_W-1:0] avg;
      logic signed [TEMP_W-1:0] mn;
      logic signed [TEMP_W-1:0] mx;
   } trec_type;

   // Divider command: a start pulse with unsigned operands.
   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   // Divider answer: done pulses for one cycle with the quotient.
   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/battery_cell_statistics.sv
// Battery cell statistics: one cell reading per req transaction. A reading
// without the last-cell mark is latched in ST_IDLE and folded in ST_UPD.
// Closing a board emits a voltage and a temperature record; each record whose
// good count is nonzero passes through the bit-serial divider, and each record
// waits on rsp_tready. A last board then scans the NUM_BOARDS stored records
// (ST_SRD, ST_SACC) and emits three pack records, each with a nonzero count
// again through the divider. No new reading is taken until the last is sent.
// Depends on bcs_pkg, bcs_div and bcs_ram.
module battery_cell_statistics #(
   parameter int CELLS_PER_BOARD = 16,
   parameter int NUM_BOARDS      = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] cell_voltage, [16] voltage_good, [32:17] cell_temp, [33] temp_good,
   // [49:34] board_temp, [50] board_temp_good, [55:51] zero
   input  logic [55:0] req_tdata,
   // [0] last_board
   input  logic [0:0]  req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] board_number, [5] valid_res, [22:6] max_value, [39:23] min_value,
   // [56:40] avg_value, [83:57] total, [90:84] bad_count, [95:91] zero
   output logic [95:0] rsp_tdata,
   // [2:0] group
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bcs_pkg::*;

   localparam int IDX_W = NUM_BOARDS > 1 ? $clog2(NUM_BOARDS) : 1;
   localparam int CNT_W = $clog2(NUM_BOARDS + 1);
   localparam logic [BAD_W-1:0] BAD_ALL = BAD_W'(CELLS_PER_BOARD);

   localparam logic [1:0] REG_VMAX = 2'd0;
   localparam logic [1:0] REG_VMIN = 2'd1;
   localparam logic [1:0] REG_TMAX = 2'd2;
   localparam logic [1:0] REG_TMIN = 2'd3;

   localparam logic [2:0] GRP_BOARD_V = 3'd0;
   localparam logic [2:0] GRP_BOARD_T = 3'd1;
   localparam logic [2:0] GRP_PACK_V  = 3'd2;

   localparam logic [1:0] PG_VOLT = 2'd0;
   localparam logic [1:0] PG_CELL = 2'd1;
   localparam logic [1:0] PG_BRD  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_UPD, ST_VSTART, ST_VWAIT, ST_VOUT, ST_TSTART, ST_TWAIT,
      ST_TOUT, ST_SRD, ST_SACC, ST_PSTART, ST_PWAIT, ST_POUT
   } state_type;

   function automatic logic [BAD_W-1:0] bad_of(input logic [GOOD_W-1:0] good);
      return (good >= BAD_ALL) ? '0 : BAD_W'(BAD_ALL - good);
   endfunction

   function automatic logic [DIV_NUM_W-1:0] mag(input logic [DIV_NUM_W-1:0] x);
      return x[DIV_NUM_W-1] ? (~x + 1'b1) : x;
   endfunction

   state_type state_ff;

   // Configuration registers.
   logic [VOLT_W-1:0]        vmax_start_ff, vmin_start_ff;
   logic signed [TEMP_W-1:0] tmax_start_ff, tmin_start_ff;
   logic                     csr_wr;
   logic [1:0]               csr_idx;

   // Latched input item.
   logic [VOLT_W-1:0]        it_v_ff;
   logic signed [TEMP_W-1:0] it_t_ff, it_bt_ff;
   logic                     it_vg_ff, it_tg_ff, it_btg_ff, it_lc_ff, it_lb_ff;

   // Running board statistics.
   logic [VOLT_W-1:0]        run_vmax_ff, run_vmin_ff;
   logic [VSUM_W-1:0]        run_vsum_ff;
   logic [GOOD_W-1:0]        run_vgood_ff, run_tgood_ff;
   logic signed [TEMP_W-1:0] run_tmax_ff, run_tmin_ff;
   logic signed [TSUM_W-1:0] run_tsum_ff;
   logic [VSUM_W:0]          vsum_in;
   logic signed [TSUM_W:0]   tsum_in;

   // Board bookkeeping and pack accumulators.
   logic [IDX_W-1:0]           cursor_ff;
   logic [CNT_W-1:0]           scan_ff;
   logic [NUM_BOARDS-1:0]      vvalid_ff, tvalid_ff;
   logic [IDX_W-1:0]           rd_addr, rd_addr_ff;
   logic signed [TEMP_W-1:0]   pbt_max_ff, pbt_min_ff;
   logic signed [BT_SUM_W-1:0] pbt_sum_ff;
   logic [BT_CNT_W-1:0]        pbt_cnt_ff;
   logic [TOTAL_W-1:0]         pvtot_ff;
   logic [VOLT_W-1:0]          pvmx_ff, pvmn_ff;
   logic [AVS_W-1:0]           pvavs_ff;
   logic [CNT_W-1:0]           pvc_ff, ptc_ff;
   logic signed [TEMP_W-1:0]   ptmx_ff, ptmn_ff;
   logic signed [AVS_W-1:0]    ptavs_ff;
   logic [1:0]                 pg_ff;
   logic signed [STAT_W-1:0]   hold_max_ff [3];
   logic signed [STAT_W-1:0]   hold_min_ff [3];
   logic signed [STAT_W-1:0]   hold_avg_ff [3];

   // Divider and record stores.
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic        neg_ff;
   logic [TEMP_W-1:0] q16;
   vrec_type    vram_rd, vrd, vnew;
   trec_type    tram_rd, trd, tnew;
   logic        v_we, t_we;

   // Pack candidate selection for the group being closed.
   logic [DIV_NUM_W-1:0]     p_dividend;
   logic [DIV_DEN_W-1:0]     p_divisor;
   logic                     p_neg;
   logic signed [STAT_W-1:0] p_max, p_min;

   // Result register.
   logic [2:0]               out_group_ff;
   logic [4:0]               out_board_ff;
   logic                     out_valid_ff, out_last_ff;
   logic signed [STAT_W-1:0] out_max_ff, out_min_ff, out_avg_ff;
   logic [TOTAL_W-1:0]       out_total_ff;
   logic [BAD_W-1:0]         out_bad_ff;

   // Configuration port: writes complete in the access phase, pready tied high.
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_idx)
         REG_VMAX: csr_prdata = {16'd0, vmax_start_ff};
         REG_VMIN: csr_prdata = {16'd0, vmin_start_ff};
         REG_TMAX: csr_prdata = {16'd0, tmax_start_ff};
         REG_TMIN: csr_prdata = {16'd0, tmin_start_ff};
         default:  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vmax_start_ff <= '0;
         vmin_start_ff <= '1;
         tmax_start_ff <= 16'sh8000;
         tmin_start_ff <= 16'sh7FFF;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_VMAX: vmax_start_ff <= csr_pwdata[15:0];
            REG_VMIN: vmin_start_ff <= csr_pwdata[15:0];
            REG_TMAX: tmax_start_ff <= csr_pwdata[15:0];
            REG_TMIN: tmin_start_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Running sums with saturation.
   always_comb begin
      vsum_in = {1'b0, run_vsum_ff} + (VSUM_W + 1)'(it_v_ff);
      if (vsum_in > {1'b0, VSUM_MAX}) begin
         vsum_in = {1'b0, VSUM_MAX};
      end
      tsum_in = (TSUM_W + 1)'(run_tsum_ff) + (TSUM_W + 1)'(it_t_ff);
      if (tsum_in > TSUM_MAX) begin
         tsum_in = TSUM_MAX;
      end else if (tsum_in < TSUM_MIN) begin
         tsum_in = TSUM_MIN;
      end
   end

   // Record stores; an entry never written reads as the reset record.
   assign rd_addr = (state_ff == ST_SRD) ? scan_ff[IDX_W-1:0] : cursor_ff;

   always_comb begin
      vrd = vram_rd;
      if (!vvalid_ff[rd_addr_ff]) begin
         vrd     = '0;
         vrd.bad = BAD_ALL;
      end
      trd = tram_rd;
      if (!tvalid_ff[rd_addr_ff]) begin
         trd     = '0;
         trd.bad = BAD_ALL;
      end
      q16 = neg_ff ? TEMP_W'(~div_rsp.quotient + 1'b1) : div_rsp.quotient[TEMP_W-1:0];
      vnew.mx  = run_vmax_ff;
      vnew.mn  = run_vmin_ff;
      vnew.sum = run_vsum_ff;
      vnew.avg = q16;
      vnew.bad = bad_of(run_vgood_ff);
      tnew.mx  = run_tmax_ff;
      tnew.mn  = run_tmin_ff;
      tnew.avg = q16;
      tnew.bad = bad_of(run_tgood_ff);
      v_we = (state_ff == ST_VWAIT) && div_rsp.done;
      t_we = (state_ff == ST_TWAIT) && div_rsp.done;
   end

   bcs_ram #(.WIDTH($bits(vrec_type)), .DEPTH(NUM_BOARDS)) u_vram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (cursor_ff),
      .wr_data (vnew),
      .rd_addr (rd_addr),
      .rd_data (vram_rd)
   );

   bcs_ram #(.WIDTH($bits(trec_type)), .DEPTH(NUM_BOARDS)) u_tram (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (cursor_ff),
      .wr_data (tnew),
      .rd_addr (rd_addr),
      .rd_data (tram_rd)
   );

   // Operands and extremes of the pack group being closed.
   always_comb begin
      case (pg_ff)
         PG_VOLT: begin
            p_dividend = DIV_NUM_W'(pvavs_ff);
            p_divisor  = DIV_DEN_W'(pvc_ff);
            p_neg      = 1'b0;
            p_max      = STAT_W'(pvmx_ff);
            p_min      = STAT_W'(pvmn_ff);
         end
         PG_CELL: begin
            p_dividend = mag(DIV_NUM_W'(ptavs_ff));
            p_divisor  = DIV_DEN_W'(ptc_ff);
            p_neg      = ptavs_ff[AVS_W-1];
            p_max      = STAT_W'(ptmx_ff);
            p_min      = STAT_W'(ptmn_ff);
         end
         default: begin
            p_dividend = mag(pbt_sum_ff);
            p_divisor  = pbt_cnt_ff;
            p_neg      = pbt_sum_ff[BT_SUM_W-1];
            p_max      = STAT_W'(pbt_max_ff);
            p_min      = STAT_W'(pbt_min_ff);
         end
      endcase
   end

   // Divider start commands from the three start states.
   always_comb begin
      div_req = '0;
      unique case (state_ff)
         ST_VSTART: begin
            div_req.start    = (run_vgood_ff != '0);
            div_req.dividend = DIV_NUM_W'(run_vsum_ff);
            div_req.divisor  = DIV_DEN_W'(run_vgood_ff);
         end
         ST_TSTART: begin
            div_req.start    = (run_tgood_ff != '0);
            div_req.dividend = mag(DIV_NUM_W'(run_tsum_ff));
            div_req.divisor  = DIV_DEN_W'(run_tgood_ff);
         end
         ST_PSTART: begin
            div_req.start    = (p_divisor != '0);
            div_req.dividend = p_dividend;
            div_req.divisor  = p_divisor;
         end
         default: ;
      endcase
   end

   bcs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_VOUT) || (state_ff == ST_TOUT) ||
                       (state_ff == ST_POUT);

   // Sequencer with the running statistics, stores bookkeeping and results.
   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         scan_ff      <= '0;
         pg_ff        <= PG_VOLT;
         vvalid_ff    <= '0;
         tvalid_ff    <= '0;
         run_vmax_ff  <= '0;
         run_vmin_ff  <= '1;
         run_vsum_ff  <= '0;
         run_vgood_ff <= '0;
         run_tmax_ff  <= 16'sh8000;
         run_tmin_ff  <= 16'sh7FFF;
         run_tsum_ff  <= '0;
         run_tgood_ff <= '0;
         pbt_max_ff   <= 16'sh8000;
         pbt_min_ff   <= 16'sh7FFF;
         pbt_sum_ff   <= '0;
         pbt_cnt_ff   <= '0;
         for (int i = 0; i < 3; i++) begin
            hold_max_ff[i] <= '0;
            hold_min_ff[i] <= '0;
            hold_avg_ff[i] <= '0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  it_v_ff   <= req_tdata[15:0];
                  it_vg_ff  <= req_tdata[16];
                  it_t_ff   <= req_tdata[32:17];
                  it_tg_ff  <= req_tdata[33];
                  it_bt_ff  <= req_tdata[49:34];
                  it_btg_ff <= req_tdata[50];
                  it_lb_ff  <= req_tuser[0];
                  it_lc_ff  <= req_tlast;
                  state_ff  <= ST_UPD;
               end
            end
            ST_UPD: begin
               if (it_vg_ff) begin
                  if (it_v_ff > run_vmax_ff) run_vmax_ff <= it_v_ff;
                  if (it_v_ff < run_vmin_ff) run_vmin_ff <= it_v_ff;
                  run_vsum_ff <= vsum_in[VSUM_W-1:0];
                  if (run_vgood_ff != GOOD_MAX) run_vgood_ff <= run_vgood_ff + 1'b1;
               end
               if (it_tg_ff) begin
                  if (it_t_ff > run_tmax_ff) run_tmax_ff <= it_t_ff;
                  if (it_t_ff < run_tmin_ff) run_tmin_ff <= it_t_ff;
                  run_tsum_ff <= tsum_in[TSUM_W-1:0];
                  if (run_tgood_ff != GOOD_MAX) run_tgood_ff <= run_tgood_ff + 1'b1;
               end
               state_ff <= it_lc_ff ? ST_VSTART : ST_IDLE;
            end
            ST_VSTART: begin
               out_group_ff <= GRP_BOARD_V;
               out_board_ff <= 5'(cursor_ff);
               out_last_ff  <= 1'b0;
               if (run_vgood_ff != '0) begin
                  neg_ff   <= 1'b0;
                  state_ff <= ST_VWAIT;
               end else begin
                  out_valid_ff <= 1'b0;
                  out_max_ff   <= STAT_W'(vrd.mx);
                  out_min_ff   <= STAT_W'(vrd.mn);
                  out_avg_ff   <= STAT_W'(vrd.avg);
                  out_total_ff <= TOTAL_W'(vrd.sum);
                  out_bad_ff   <= vrd.bad;
                  state_ff     <= ST_VOUT;
               end
            end
            ST_VWAIT: begin
               if (div_rsp.done) begin
                  vvalid_ff[cursor_ff] <= 1'b1;
                  out_valid_ff <= 1'b1;
                  out_max_ff   <= STAT_W'(vnew.mx);
                  out_min_ff   <= STAT_W'(vnew.mn);
                  out_avg_ff   <= STAT_W'(vnew.avg);
                  out_total_ff <= TOTAL_W'(vnew.sum);
                  out_bad_ff   <= vnew.bad;
                  state_ff     <= ST_VOUT;
               end
            end
            ST_VOUT: begin
               if (rsp_tready) state_ff <= ST_TSTART;
            end
            ST_TSTART: begin
               out_group_ff <= GRP_BOARD_T;
               out_total_ff <= '0;
               out_last_ff  <= !it_lb_ff;
               if (run_tgood_ff != '0) begin
                  neg_ff   <= run_tsum_ff[TSUM_W-1];
                  state_ff <= ST_TWAIT;
               end else begin
                  out_valid_ff <= 1'b0;
                  out_max_ff   <= STAT_W'(trd.mx);
                  out_min_ff   <= STAT_W'(trd.mn);
                  out_avg_ff   <= STAT_W'(trd.avg);
                  out_bad_ff   <= trd.bad;
                  state_ff     <= ST_TOUT;
               end
            end
            ST_TWAIT: begin
               if (div_rsp.done) begin
                  tvalid_ff[cursor_ff] <= 1'b1;
                  out_valid_ff <= 1'b1;
                  out_max_ff   <= STAT_W'(tnew.mx);
                  out_min_ff   <= STAT_W'(tnew.mn);
                  out_avg_ff   <= STAT_W'(tnew.avg);
                  out_bad_ff   <= tnew.bad;
                  state_ff     <= ST_TOUT;
               end
            end
            ST_TOUT: begin
               if (rsp_tready) begin
                  // Fold in the board temperature and restart the board runs.
                  if (it_btg_ff) begin
                     if (it_bt_ff > pbt_max_ff) pbt_max_ff <= it_bt_ff;
                     if (it_bt_ff < pbt_min_ff) pbt_min_ff <= it_bt_ff;
                     pbt_sum_ff <= pbt_sum_ff + BT_SUM_W'(it_bt_ff);
                     pbt_cnt_ff <= pbt_cnt_ff + 1'b1;
                  end
                  run_vmax_ff  <= vmax_start_ff;
                  run_vmin_ff  <= vmin_start_ff;
                  run_vsum_ff  <= '0;
                  run_vgood_ff <= '0;
                  run_tmax_ff  <= tmax_start_ff;
                  run_tmin_ff  <= tmin_start_ff;
                  run_tsum_ff  <= '0;
                  run_tgood_ff <= '0;
                  if (it_lb_ff) begin
                     scan_ff  <= '0;
                     pvtot_ff <= '0;
                     pvmx_ff  <= vmax_start_ff;
                     pvmn_ff  <= vmin_start_ff;
                     pvavs_ff <= '0;
                     pvc_ff   <= '0;
                     ptmx_ff  <= tmax_start_ff;
                     ptmn_ff  <= tmin_start_ff;
                     ptavs_ff <= '0;
                     ptc_ff   <= '0;
                     state_ff <= ST_SRD;
                  end else begin
                     cursor_ff <= (cursor_ff == IDX_W'(NUM_BOARDS - 1)) ? '0 :
                                  cursor_ff + 1'b1;
                     state_ff  <= ST_IDLE;
                  end
               end
            end
            ST_SRD: begin
               state_ff <= ST_SACC;
            end
            ST_SACC: begin
               // One stored board per visit enters the pack accumulators.
               pvtot_ff <= pvtot_ff + TOTAL_W'(vrd.sum);
               if (vrd.bad < BAD_ALL) begin
                  if (vrd.mx > pvmx_ff) pvmx_ff <= vrd.mx;
                  if (vrd.mn < pvmn_ff) pvmn_ff <= vrd.mn;
                  pvavs_ff <= pvavs_ff + AVS_W'(vrd.avg);
                  pvc_ff   <= pvc_ff + 1'b1;
               end
               if (trd.bad < BAD_ALL) begin
                  if (trd.mx > ptmx_ff) ptmx_ff <= trd.mx;
                  if (trd.mn < ptmn_ff) ptmn_ff <= trd.mn;
                  ptavs_ff <= ptavs_ff + AVS_W'(trd.avg);
                  ptc_ff   <= ptc_ff + 1'b1;
               end
               if (scan_ff == CNT_W'(NUM_BOARDS - 1)) begin
                  pg_ff    <= PG_VOLT;
                  state_ff <= ST_PSTART;
               end else begin
                  scan_ff  <= scan_ff + 1'b1;
                  state_ff <= ST_SRD;
               end
            end
            ST_PSTART: begin
               out_group_ff <= GRP_PACK_V + 3'(pg_ff);
               out_board_ff <= '0;
               out_bad_ff   <= '0;
               out_total_ff <= (pg_ff == PG_VOLT) ? pvtot_ff : '0;
               out_last_ff  <= (pg_ff == PG_BRD);
               if (p_divisor != '0) begin
                  neg_ff   <= p_neg;
                  state_ff <= ST_PWAIT;
               end else begin
                  out_valid_ff <= 1'b0;
                  out_max_ff   <= hold_max_ff[pg_ff];
                  out_min_ff   <= hold_min_ff[pg_ff];
                  out_avg_ff   <= hold_avg_ff[pg_ff];
                  state_ff     <= ST_POUT;
               end
            end
            ST_PWAIT: begin
               if (div_rsp.done) begin
                  hold_max_ff[pg_ff] <= p_max;
                  hold_min_ff[pg_ff] <= p_min;
                  out_valid_ff <= 1'b1;
                  out_max_ff   <= p_max;
                  out_min_ff   <= p_min;
                  if (pg_ff == PG_VOLT) begin
                     hold_avg_ff[pg_ff] <= STAT_W'(q16);
                     out_avg_ff         <= STAT_W'(q16);
                  end else begin
                     hold_avg_ff[pg_ff] <= STAT_W'(signed'(q16));
                     out_avg_ff         <= STAT_W'(signed'(q16));
                  end
                  state_ff <= ST_POUT;
               end
            end
            ST_POUT: begin
               if (rsp_tready) begin
                  if (pg_ff == PG_BRD) begin
                     pbt_max_ff <= tmax_start_ff;
                     pbt_min_ff <= tmin_start_ff;
                     pbt_sum_ff <= '0;
                     pbt_cnt_ff <= '0;
                     cursor_ff  <= '0;
                     state_ff   <= ST_IDLE;
                  end else begin
                     pg_ff    <= pg_ff + 1'b1;
                     state_ff <= ST_PSTART;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tuser = out_group_ff;
   assign rsp_tlast = out_last_ff;
   assign rsp_tdata = {5'd0, out_bad_ff, out_total_ff, out_avg_ff, out_min_ff,
                       out_max_ff, out_valid_ff, out_board_ff};

   // The block never offers a result while taking a new reading.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("result offered while accepting a reading");

   // The final result of a reading hands control back to the input side.
   a_last_frees_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("input not ready after the final result");

   // A quotient only arrives while the sequencer waits for one.
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_VWAIT || state_ff == ST_TWAIT ||
                        state_ff == ST_PWAIT))
      else $error("divider finished outside a wait state");

   // The pack scan stays within the stored boards.
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SACC) |-> (scan_ff < CNT_W'(NUM_BOARDS)))
      else $error("pack scan beyond the last board");
endmodule

// File: rtl/bcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module bcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/bcs_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on bcs_pkg for the operand widths and request/response types.
module bcs_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bcs_pkg::div_req_type req,
   output bcs_pkg::div_rsp_type rsp
);
   import bcs_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_NUM_W-1:0] num_ff;
   logic [DIV_DEN_W:0]   rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W:0]   trial;
   logic                 qbit;
   logic [DIV_DEN_W:0]   rem_in;

   // Shift the next dividend bit into the partial remainder and try a subtract.
   always_comb begin
      trial  = {rem_ff[DIV_DEN_W-1:0], num_ff[DIV_NUM_W-1]};
      qbit   = (trial >= {1'b0, den_ff});
      rem_in = qbit ? (trial - {1'b0, den_ff}) : trial;
   end

   // Sequencer and shift registers; the quotient fills num_ff from the bottom.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            num_ff  <= req.dividend;
            den_ff  <= req.divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            num_ff <= {num_ff[DIV_NUM_W-2:0], qbit};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = num_ff;
endmodule
